// File: rtl/rc4_pkg.sv
// Shared constants, codes and controller-to-datapath types of the RC4 engine.
package rc4_pkg;

    localparam int FUNC_W = 2;
    localparam int BYTE_W = 8;
    localparam int KLEN_W = 9;

    localparam logic [FUNC_W-1:0] FUNC_LOAD  = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_SCHED = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_CRYPT = 2'd2;

    localparam logic [KLEN_W-1:0] KLEN_RESET = 9'd1;

    typedef enum logic [3:0] {
        DP_NOP,
        DP_LOAD,
        DP_SCHED_START,
        DP_ENC_START,
        DP_FILL,
        DP_CALC_J,
        DP_WRITE_I,
        DP_WRITE_J,
        DP_WAIT,
        DP_EMIT
    } t_dp_op;

    typedef struct packed {
        t_dp_op op;
        logic   ksa;
    } t_dp_cmd;

    typedef struct packed {
        logic fill_last;
        logic ksa_last;
        logic out_free;
    } t_dp_sts;

endpackage

// File: rtl/rc4_req_if.sv
// Request channel interface carrying one RC4 request and its handshake.
interface rc4_req_if;
    logic                        valid;
    logic                        ready;
    logic [rc4_pkg::FUNC_W-1:0]  func;
    logic [rc4_pkg::BYTE_W-1:0]  key_index;
    logic [rc4_pkg::BYTE_W-1:0]  key_byte;
    logic [rc4_pkg::BYTE_W-1:0]  data_in;
    logic                        end_of_message;

    modport source (output valid, func, key_index, key_byte, data_in, end_of_message,
                    input ready);
    modport sink   (input valid, func, key_index, key_byte, data_in, end_of_message,
                    output ready);
endinterface

// File: rtl/rc4_res_if.sv
// Result channel interface carrying one processed data byte and its handshake.
interface rc4_res_if;
    logic                        valid;
    logic                        ready;
    logic [rc4_pkg::BYTE_W-1:0]  data_out;
    logic                        last;

    modport source (output valid, data_out, last, input ready);
    modport sink   (input valid, data_out, last, output ready);
endinterface

// File: rtl/rc4_cfg_if.sv
// Configuration write channel interface carrying the key length register.
interface rc4_cfg_if;
    logic                        valid;
    logic                        ready;
    logic [rc4_pkg::KLEN_W-1:0]  key_length;

    modport source (output valid, key_length, input ready);
    modport sink   (input valid, key_length, output ready);
endinterface

// File: rtl/rc4_ctrl.sv
// Sequencing state machine of the RC4 engine.
module rc4_ctrl (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_req_valid,
    output logic                        o_req_ready,
    input  logic [rc4_pkg::FUNC_W-1:0]  i_func,
    output rc4_pkg::t_dp_cmd            o_cmd,
    input  rc4_pkg::t_dp_sts            i_sts
);
    import rc4_pkg::*;

    typedef enum logic [6:0] {
        ST_INIT = 7'b0000001,
        ST_IDLE = 7'b0000010,
        ST_READ = 7'b0000100,
        ST_CALC = 7'b0001000,
        ST_WR_I = 7'b0010000,
        ST_WR_J = 7'b0100000,
        ST_OUT  = 7'b1000000
    } t_state;

    t_state r_state, n_state;
    logic   r_ksa, n_ksa;

    always_comb begin
        n_state     = r_state;
        n_ksa       = r_ksa;
        o_cmd.op    = DP_NOP;
        o_cmd.ksa   = r_ksa;
        o_req_ready = 1'b0;
        unique case (r_state)
            ST_INIT: begin
                o_cmd.op = DP_FILL;
                if (i_sts.fill_last) begin
                    n_state = r_ksa ? ST_READ : ST_IDLE;
                end
            end
            ST_IDLE: begin
                o_req_ready = 1'b1;
                if (i_req_valid) begin
                    unique case (i_func)
                        FUNC_LOAD: begin
                            o_cmd.op = DP_LOAD;
                        end
                        FUNC_SCHED: begin
                            o_cmd.op = DP_SCHED_START;
                            n_ksa    = 1'b1;
                            n_state  = ST_INIT;
                        end
                        FUNC_CRYPT: begin
                            o_cmd.op = DP_ENC_START;
                            n_ksa    = 1'b0;
                            n_state  = ST_CALC;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_READ: begin
                n_state = ST_CALC;
            end
            ST_CALC: begin
                o_cmd.op = DP_CALC_J;
                n_state  = ST_WR_I;
            end
            ST_WR_I: begin
                o_cmd.op = DP_WRITE_I;
                n_state  = ST_WR_J;
            end
            ST_WR_J: begin
                o_cmd.op = DP_WRITE_J;
                if (r_ksa) begin
                    n_state = i_sts.ksa_last ? ST_IDLE : ST_READ;
                end else begin
                    n_state = ST_OUT;
                end
            end
            ST_OUT: begin
                if (i_sts.out_free) begin
                    o_cmd.op = DP_EMIT;
                    n_state  = ST_IDLE;
                end else begin
                    o_cmd.op = DP_WAIT;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_INIT;
            r_ksa   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ksa   <= n_ksa;
        end
    end

`ifndef SYNTHESIS
    // An accepted data byte reaches the result step after the calculate, write-i and write-j states.
    a_crypt_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req_valid && o_req_ready && i_func == FUNC_CRYPT) |-> ##4 (r_state == ST_OUT))
        else $error("data request did not reach the result step on time");
`endif

endmodule

// File: rtl/rc4_dp.sv
// Datapath of the RC4 engine: permutation table, key store, pointers and result register.
module rc4_dp #(
    parameter int KEY_DEPTH = 256
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic [rc4_pkg::BYTE_W-1:0]  i_key_index,
    input  logic [rc4_pkg::BYTE_W-1:0]  i_key_byte,
    input  logic [rc4_pkg::BYTE_W-1:0]  i_data_in,
    input  logic                        i_end_of_message,
    rc4_cfg_if.sink                     i_cfg,
    rc4_res_if.source                   o_res,
    input  rc4_pkg::t_dp_cmd            i_cmd,
    output rc4_pkg::t_dp_sts            o_sts
);
    import rc4_pkg::*;

    localparam int KEY_AW = (KEY_DEPTH > 1) ? $clog2(KEY_DEPTH) : 1;
    localparam logic [KLEN_W-1:0] DEPTH_K = KLEN_W'(KEY_DEPTH);

    logic [BYTE_W-1:0] r_perm [256];
    logic [BYTE_W-1:0] r_key  [KEY_DEPTH];

    logic [BYTE_W-1:0] r_rd, r_key_rd;
    logic [BYTE_W-1:0] r_i, r_j, r_cnt;
    logic [KEY_AW-1:0] r_k;
    logic [KLEN_W-1:0] r_key_length;
    logic [BYTE_W-1:0] r_si, r_sj, r_t, r_din;
    logic              r_eom;
    logic              r_out_valid;
    logic [BYTE_W-1:0] r_out_data;
    logic              r_out_last;

    logic [BYTE_W-1:0] rd_addr, perm_wa, perm_wd;
    logic              perm_we, key_we;
    logic [BYTE_W-1:0] j_sum, t_sum, ks;
    logic [KLEN_W-1:0] len_eff, k_inc;
    logic [KEY_AW-1:0] k_next;

    // Key length as used by the schedule: zero counts as one, large values saturate.
    always_comb begin
        if (r_key_length == '0) begin
            len_eff = KLEN_W'(1);
        end else if (r_key_length > DEPTH_K) begin
            len_eff = DEPTH_K;
        end else begin
            len_eff = r_key_length;
        end
    end

    assign k_inc  = {{(KLEN_W-KEY_AW){1'b0}}, r_k} + KLEN_W'(1);
    assign k_next = (k_inc >= len_eff) ? '0 : k_inc[KEY_AW-1:0];

    assign j_sum = r_j + r_rd + (i_cmd.ksa ? r_key_rd : '0);
    assign t_sum = r_si + r_sj;
    // The table read for the keystream byte misses the second swap write, so patch it.
    assign ks    = (r_t == r_j) ? r_si : r_rd;

    assign key_we = (i_cmd.op == DP_LOAD) && ({1'b0, i_key_index} < DEPTH_K);

    always_comb begin
        rd_addr = r_i + 8'd1;
        perm_we = 1'b0;
        perm_wa = r_i;
        perm_wd = r_rd;
        unique case (i_cmd.op)
            DP_FILL: begin
                perm_we = 1'b1;
                perm_wa = r_cnt;
                perm_wd = r_cnt;
            end
            DP_CALC_J: begin
                rd_addr = j_sum;
            end
            DP_WRITE_I: begin
                perm_we = 1'b1;
                perm_wa = r_i;
                perm_wd = r_rd;
            end
            DP_WRITE_J: begin
                perm_we = 1'b1;
                perm_wa = r_j;
                perm_wd = r_si;
                rd_addr = t_sum;
            end
            DP_WAIT: begin
                // Hold the keystream entry in the read register while the result waits.
                rd_addr = r_t;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (perm_we) begin
            r_perm[perm_wa] <= perm_wd;
        end
        r_rd <= r_perm[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (key_we) begin
            r_key[i_key_index[KEY_AW-1:0]] <= i_key_byte;
        end
        r_key_rd <= r_key[r_k];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_i          <= '0;
            r_j          <= '0;
            r_cnt        <= '0;
            r_k          <= '0;
            r_key_length <= KLEN_RESET;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg.valid) begin
                r_key_length <= i_cfg.key_length;
            end
            case (i_cmd.op)
                DP_SCHED_START: begin
                    r_i <= 8'hFF;
                    r_j <= '0;
                    r_k <= '0;
                end
                DP_FILL: begin
                    r_cnt <= r_cnt + 8'd1;
                end
                DP_CALC_J: begin
                    r_j <= j_sum;
                    r_i <= r_i + 8'd1;
                    if (i_cmd.ksa) begin
                        r_k <= k_next;
                    end
                end
                DP_WRITE_J: begin
                    if (i_cmd.ksa && r_i == 8'hFF) begin
                        r_i <= '0;
                        r_j <= '0;
                    end
                end
                default: begin
                end
            endcase
            if (i_cmd.op == DP_EMIT) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            DP_ENC_START: begin
                r_din <= i_data_in;
                r_eom <= i_end_of_message;
            end
            DP_CALC_J: begin
                r_si <= r_rd;
            end
            DP_WRITE_I: begin
                r_sj <= r_rd;
            end
            DP_WRITE_J: begin
                r_t <= t_sum;
            end
            DP_EMIT: begin
                r_out_data <= r_din ^ ks;
                r_out_last <= r_eom;
            end
            default: begin
            end
        endcase
    end

    assign i_cfg.ready    = 1'b1;
    assign o_res.valid    = r_out_valid;
    assign o_res.data_out = r_out_data;
    assign o_res.last     = r_out_last;

    assign o_sts.fill_last = (r_cnt == 8'hFF);
    assign o_sts.ksa_last  = (r_i == 8'hFF);
    assign o_sts.out_free  = !r_out_valid || o_res.ready;

`ifndef SYNTHESIS
    // A new result must never overwrite one that has not been taken.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.op == DP_EMIT) |-> (!r_out_valid || o_res.ready))
        else $error("result register overwritten while still pending");
    // The last swap of the schedule leaves both pointers cleared.
    a_ptr_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.op == DP_WRITE_J && i_cmd.ksa && r_i == 8'hFF) |=> (r_i == '0 && r_j == '0))
        else $error("pointers not cleared after key schedule");
    // The key length used by the schedule always lies within the key store.
    a_len_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (len_eff != '0) && (len_eff <= DEPTH_K))
        else $error("effective key length out of range");
`endif

endmodule

// File: rtl/rc4_stream_cipher_core.sv
// Top level of the RC4 stream cipher engine.
//
//  Channel  Direction  Handshake     Carries
//  i_req    in         valid/ready   func, key_index, key_byte, data_in, end_of_message
//  o_res    out        valid/ready   data_out, last
//  i_cfg    in         valid/ready   key_length (always ready)
//
// After reset a clearing pass writes the identity permutation into all 256 entries; no
// request is accepted during it, though configuration writes are. A load request leaves
// the engine idle, ready for the next one; a data request passes the calculate, write-i,
// write-j and output states before the next acceptance, set by the single write port
// of the permutation table (two writes per swap) and the dependent reads of i, j and the
// keystream index. A schedule request runs the identity fill, then a key step of read,
// calculate, write-i and write-j states for each of the 256 entries, for the same reason.
// A pending result that is not taken stalls the engine only in its final step, so the
// next request is accepted while the previous result still waits.
module rc4_stream_cipher_core #(
    parameter int KEY_DEPTH = 256
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    rc4_req_if.sink    i_req,
    rc4_res_if.source  o_res,
    rc4_cfg_if.sink    i_cfg
);
    import rc4_pkg::*;

    // The controller and the datapath share nothing but this command and status.
    t_dp_cmd cmd;
    t_dp_sts sts;

    // The controller owns the request handshake and decodes the function code.
    rc4_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .o_req_ready (i_req.ready),
        .i_func      (i_req.func),
        .o_cmd       (cmd),
        .i_sts       (sts)
    );

    // The datapath holds all state of the cipher, the key length register and the
    // result register that parts the engine from the result channel.
    rc4_dp #(
        .KEY_DEPTH (KEY_DEPTH)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_key_index      (i_req.key_index),
        .i_key_byte       (i_req.key_byte),
        .i_data_in        (i_req.data_in),
        .i_end_of_message (i_req.end_of_message),
        .i_cfg            (i_cfg),
        .o_res            (o_res),
        .i_cmd            (cmd),
        .o_sts            (sts)
    );

endmodule

// File: tb/rc4_stream_cipher_core_test.sv
// Self-checking testbench of the RC4 stream cipher core with random handshakes and key lengths.
`timescale 1ns / 100ps

module rc4_stream_cipher_core_test;

    import rc4_pkg::*;

    // The block is built with its default key store depth.
    localparam int KEY_DEPTH = 256;

    // The fourth function code is unused and the block must ignore it.
    localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

    // A key schedule yields no result, so the block may still be busy with one after the
    // last output byte has gone. This settling time covers it.
    localparam int SETTLE_CYCLES = 1400;
    localparam int CYCLE_LIMIT   = 1000000;

    // The receiver holds off once, for a long stretch, after this many requests.
    localparam int HOLD_AFTER_REQS = 700;
    localparam int HOLD_CYCLES     = 300;

    localparam int PHASES     = 8;
    localparam int PHASE_REQS = 200;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [BYTE_W-1:0] key_index;
        logic [BYTE_W-1:0] key_byte;
        logic [BYTE_W-1:0] data_in;
        logic              eom;
    } t_rc4_req;

    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              last;
    } t_rc4_out;

    logic i_clk;
    logic i_rst_n;

    rc4_req_if req_ch ();
    rc4_res_if res_ch ();
    rc4_cfg_if cfg_ch ();

    rc4_stream_cipher_core DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_res   (res_ch),
        .i_cfg   (cfg_ch)
    );

    // Stimulus side: requests waiting to be driven and the generator's view of the key.
    t_rc4_req      req_backlog[$];
    int            queued_total;
    bit            key_seen[KEY_DEPTH];
    logic [KLEN_W-1:0] gen_key_len;

    // Prediction side: the cipher state as it should stand inside the block.
    logic [BYTE_W-1:0] perm_mem[256];
    logic [BYTE_W-1:0] key_mem[KEY_DEPTH];
    logic [BYTE_W-1:0] walk_i;
    logic [BYTE_W-1:0] walk_j;
    logic [KLEN_W-1:0] key_len_reg;
    t_rc4_out          cipher_bytes_q[$];

    // Handshake bookkeeping, sampled at the rising edge and read at the falling edge.
    logic req_fire;
    logic cfg_fire;
    int   req_total;
    int   mismatch_count;
    int   cycle_count;

    // Idling control.
    bit   calm;
    int   send_gap;
    int   recv_gap;
    int   hold_left;
    bit   hold_done;

    // Clock, and every input of the block at a known value from time zero.
    initial begin
        i_clk               = 1'b0;
        i_rst_n             = 1'b0;
        req_ch.valid        = 1'b0;
        req_ch.func         = FUNC_LOAD;
        req_ch.key_index    = '0;
        req_ch.key_byte     = '0;
        req_ch.data_in      = '0;
        req_ch.end_of_message = 1'b0;
        res_ch.ready        = 1'b0;
        cfg_ch.valid        = 1'b0;
        cfg_ch.key_length   = KLEN_RESET;
        forever #6 i_clk = ~i_clk;
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch: %s got %0h want %0h", what, got, want);
        mismatch_count++;
    endtask

    // ---------------------------------------------------------------------------------
    // Predictor of the cipher. The key schedule rebuilds the permutation from identity
    // and mixes in the key bytes cyclically; each data byte takes one keystream step.
    // ---------------------------------------------------------------------------------
    function automatic void run_key_schedule();
        int                n;
        int                len;
        logic [BYTE_W-1:0] acc;
        logic [BYTE_W-1:0] tmp;
        // A zero length behaves as one, and a length past the store depth saturates.
        len = int'(key_len_reg);
        if (len == 0) len = 1;
        if (len > KEY_DEPTH) len = KEY_DEPTH;
        for (n = 0; n < 256; n++) perm_mem[n] = n[BYTE_W-1:0];
        acc = '0;
        for (n = 0; n < 256; n++) begin
            acc         = acc + perm_mem[n] + key_mem[n % len];
            tmp         = perm_mem[n];
            perm_mem[n] = perm_mem[acc];
            perm_mem[acc] = tmp;
        end
        walk_i = '0;
        walk_j = '0;
    endfunction

    function automatic logic [BYTE_W-1:0] next_key_byte();
        logic [BYTE_W-1:0] tmp;
        logic [BYTE_W-1:0] sum;
        walk_i           = walk_i + 8'd1;
        walk_j           = walk_j + perm_mem[walk_i];
        tmp              = perm_mem[walk_i];
        perm_mem[walk_i] = perm_mem[walk_j];
        perm_mem[walk_j] = tmp;
        sum              = perm_mem[walk_i] + perm_mem[walk_j];
        return perm_mem[sum];
    endfunction

    function automatic void apply_rc4_request(input t_rc4_req r);
        t_rc4_out res;
        case (r.func)
            FUNC_LOAD: begin
                key_mem[r.key_index] = r.key_byte;
            end
            FUNC_SCHED: begin
                run_key_schedule();
            end
            FUNC_CRYPT: begin
                res.data = r.data_in ^ next_key_byte();
                res.last = r.eom;
                cipher_bytes_q.push_back(res);
            end
            default: begin
                // The unused code changes nothing.
            end
        endcase
    endfunction

    // ---------------------------------------------------------------------------------
    // Monitor: requests and configuration writes feed the predictor when accepted, and
    // each accepted output byte is checked against the oldest prediction.
    // ---------------------------------------------------------------------------------
    initial begin
        int n;
        for (n = 0; n < 256; n++) perm_mem[n] = n[BYTE_W-1:0];
        walk_i         = '0;
        walk_j         = '0;
        key_len_reg    = KLEN_RESET;
        req_fire       = 1'b0;
        cfg_fire       = 1'b0;
        req_total      = 0;
        mismatch_count = 0;
        cycle_count    = 0;
        send_gap       = 0;
        recv_gap       = 0;
        hold_left      = 0;
        hold_done      = 1'b0;
    end

    always @(posedge i_clk) begin
        t_rc4_req got_req;
        t_rc4_out want;
        req_fire <= i_rst_n && req_ch.valid && req_ch.ready;
        cfg_fire <= i_rst_n && cfg_ch.valid && cfg_ch.ready;
        if (i_rst_n) begin
            if (cfg_ch.valid && cfg_ch.ready) begin
                key_len_reg = cfg_ch.key_length;
            end
            if (req_ch.valid && req_ch.ready) begin
                got_req.func      = req_ch.func;
                got_req.key_index = req_ch.key_index;
                got_req.key_byte  = req_ch.key_byte;
                got_req.data_in   = req_ch.data_in;
                got_req.eom       = req_ch.end_of_message;
                apply_rc4_request(got_req);
                req_total <= req_total + 1;
            end
            if (res_ch.valid && res_ch.ready) begin
                if (cipher_bytes_q.size() == 0) begin
                    report_mismatch("output byte with nothing expected",
                                    int'(res_ch.data_out), 0);
                end else begin
                    want = cipher_bytes_q.pop_front();
                    if (res_ch.data_out !== want.data) begin
                        report_mismatch("data_out", int'(res_ch.data_out), int'(want.data));
                    end
                    if (res_ch.last !== want.last) begin
                        report_mismatch("last", int'(res_ch.last), int'(want.last));
                    end
                end
            end
        end
    end

    // A run that never drains is cut off here.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // The long hold-off of the receiver is counted in a process of its own. The sender
    // keeps offering requests meanwhile, so the block fills up and stalls its input.
    always @(posedge i_clk) begin
        if (!hold_done && req_total >= HOLD_AFTER_REQS) begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // ---------------------------------------------------------------------------------
    // Driver: takes the next request from the backlog once the previous one has been
    // accepted, with random idle bursts unless the run is calm.
    // ---------------------------------------------------------------------------------
    always @(negedge i_clk) begin
        t_rc4_req nxt;
        logic     offer;
        nxt   = '0;
        offer = 1'b0;
        if (!i_rst_n) begin
            req_ch.valid <= 1'b0;
        end else if (!req_ch.valid || req_fire) begin
            if (send_gap > 0) begin
                send_gap--;
            end else if (req_backlog.size() != 0) begin
                if (!calm && $urandom_range(0, 7) == 0) begin
                    send_gap = $urandom_range(0, 3);
                end else begin
                    nxt   = req_backlog.pop_front();
                    offer = 1'b1;
                end
            end
            req_ch.valid <= offer;
            if (offer) begin
                req_ch.func           <= nxt.func;
                req_ch.key_index      <= nxt.key_index;
                req_ch.key_byte       <= nxt.key_byte;
                req_ch.data_in        <= nxt.data_in;
                req_ch.end_of_message <= nxt.eom;
            end
        end
    end

    // Receiver: ready drops in random bursts, and for the whole of the long hold-off.
    always @(negedge i_clk) begin
        logic take;
        take = 1'b1;
        if (!i_rst_n) begin
            take = 1'b0;
        end else if (hold_left > 0) begin
            take = 1'b0;
        end else if (recv_gap > 0) begin
            recv_gap--;
            take = 1'b0;
        end else if (!calm && $urandom_range(0, 5) == 0) begin
            recv_gap = $urandom_range(0, 3);
            take     = 1'b0;
        end
        res_ch.ready <= take;
    end

    // ---------------------------------------------------------------------------------
    // Request generation. The generator tracks which key bytes have been loaded, so that
    // a schedule never reads a key store entry that was never written.
    // ---------------------------------------------------------------------------------
    task automatic push_req(input logic [FUNC_W-1:0] f, input logic [BYTE_W-1:0] ki,
                            input logic [BYTE_W-1:0] kb, input logic [BYTE_W-1:0] d,
                            input logic e);
        t_rc4_req r;
        r.func      = f;
        r.key_index = ki;
        r.key_byte  = kb;
        r.data_in   = d;
        r.eom       = e;
        req_backlog.push_back(r);
        queued_total++;
    endtask

    task automatic queue_load(input logic [BYTE_W-1:0] idx, input logic [BYTE_W-1:0] b);
        push_req(FUNC_LOAD, idx, b, BYTE_W'($urandom_range(0, 255)),
                 1'($urandom_range(0, 1)));
        key_seen[idx] = 1'b1;
    endtask

    task automatic queue_sched();
        int len;
        int k;
        len = int'(gen_key_len);
        if (len == 0) len = 1;
        if (len > KEY_DEPTH) len = KEY_DEPTH;
        for (k = 0; k < len; k++) begin
            if (!key_seen[k]) queue_load(BYTE_W'(k), BYTE_W'($urandom_range(0, 255)));
        end
        push_req(FUNC_SCHED, BYTE_W'($urandom_range(0, 255)), BYTE_W'($urandom_range(0, 255)),
                 BYTE_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
    endtask

    // A message is a run of data bytes with end_of_message set on the final one.
    task automatic queue_message(input int len);
        int k;
        for (k = 0; k < len; k++) begin
            push_req(FUNC_CRYPT, BYTE_W'($urandom_range(0, 255)),
                     BYTE_W'($urandom_range(0, 255)), BYTE_W'($urandom_range(0, 255)),
                     k == len - 1);
        end
    endtask

    // Mostly well-formed traffic: a fresh schedule, then messages of random length,
    // with occasional key loads, reschedules and requests carrying the unused code.
    task automatic queue_random_phase(input int count);
        int start;
        int pick;
        queue_sched();
        start = queued_total;
        while (queued_total - start < count) begin
            pick = $urandom_range(0, 99);
            if (pick < 2) begin
                queue_sched();
            end else if (pick < 5) begin
                push_req(FUNC_UNUSED, BYTE_W'($urandom_range(0, 255)),
                         BYTE_W'($urandom_range(0, 255)), BYTE_W'($urandom_range(0, 255)),
                         1'($urandom_range(0, 1)));
            end else if (pick < 10) begin
                queue_load(BYTE_W'($urandom_range(0, 255)), BYTE_W'($urandom_range(0, 255)));
            end else begin
                queue_message($urandom_range(1, 12));
            end
        end
    endtask

    // Waits until every queued request has been accepted and every output byte checked.
    task automatic wait_drained();
        do @(negedge i_clk);
        while (req_total != queued_total || cipher_bytes_q.size() != 0);
    endtask

    // The key length register is only written while the block is idle, after the
    // settling time that covers a schedule still in progress.
    task automatic write_key_length(input logic [KLEN_W-1:0] value);
        wait_drained();
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        cfg_ch.valid      <= 1'b1;
        cfg_ch.key_length <= value;
        do @(negedge i_clk);
        while (!cfg_fire);
        cfg_ch.valid <= 1'b0;
        gen_key_len = value;
    endtask

    // ---------------------------------------------------------------------------------
    // Test sequence.
    // ---------------------------------------------------------------------------------
    initial begin
        int                p;
        logic [KLEN_W-1:0] plan[PHASES];
        queued_total = 0;
        gen_key_len  = KLEN_RESET;
        calm         = 1'b0;
        // Zero and the values past the store depth exercise the clamping of the length.
        plan = '{9'd0, 9'd256, 9'd511, 9'd300, 9'd2, 9'd1, 9'd17, 9'd0};
        plan[PHASES-1] = KLEN_W'($urandom_range(1, 511));

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part with the reset key length of one. Data before any schedule runs
        // on the identity permutation.
        push_req(FUNC_CRYPT, 8'h00, 8'h00, 8'h00, 1'b0);
        push_req(FUNC_CRYPT, 8'hFF, 8'hFF, 8'hFF, 1'b1);
        push_req(FUNC_UNUSED, 8'hFF, 8'hFF, 8'hFF, 1'b1);
        queue_load(8'h00, 8'hFF);
        queue_load(8'hFF, 8'h00);
        queue_load(8'h80, 8'h5A);
        queue_sched();
        push_req(FUNC_CRYPT, 8'h00, 8'h00, 8'h00, 1'b0);
        push_req(FUNC_CRYPT, 8'h00, 8'h00, 8'hFF, 1'b0);
        push_req(FUNC_CRYPT, 8'h00, 8'h00, 8'h5A, 1'b1);
        // Fields that do not belong to a request's function must be ignored.
        queue_load(8'h01, 8'h00);
        push_req(FUNC_UNUSED, 8'h00, 8'h00, 8'h00, 1'b0);
        push_req(FUNC_CRYPT, 8'hFF, 8'hFF, 8'h0F, 1'b0);
        queue_sched();
        queue_message(4);

        // Random phases, each with its own key length; the last one runs without idling.
        for (p = 0; p < PHASES; p++) begin
            write_key_length(plan[p]);
            calm = (p == PHASES - 1);
            @(posedge i_clk);
            queue_random_phase(PHASE_REQS);
        end

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (cipher_bytes_q.size() != 0) begin
            report_mismatch("output bytes never delivered", 0, cipher_bytes_q.size());
        end
        if (mismatch_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
